[rtl/core/nab_pkg.sv]
// shared constants for the necklace address book
`default_nettype none
package nab_pkg;
    localparam int DIGIT_W = 4;
    localparam int MAX_DIG = 16;
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [0:0] CFG_BASE  = 1'd0;
    localparam logic [0:0] CFG_PAIRS = 1'd1;
endpackage
`default_nettype wire

[rtl/core/necklace_address_book.sv]
// necklace address book: digit split, minimal rotation, binary search, sorted insert, clear
// an input word is split into digits by repeated division by the radix (n-1 digits plus a check
// digit for insert, n digits for lookup), every rotation is evaluated to find the minimum, the
// table is binary searched and probed, and on insert the entries above the position shift up.
// one word is in work at a time; a new input word is taken once the result register frees.
// synchronous active-low reset: base 2, pairs 2, one entry (zero) written at address zero.
`default_nettype none
module necklace_address_book #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_DIGITS  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [4:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // [1:0] mode, [65:2] sequence_req, rest zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [87:0] m_axis_tdata    // [63:0] canonical, [73:64] position, [74] found,
                                        // [75] added, [76] overflow, [87:77] entries
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DC = $clog2(MAX_DIGITS + 1);
    localparam int DI = $clog2(MAX_DIGITS);
    localparam int DIGIT_W_T = nab_pkg::DIGIT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001, S_SPLIT = 10'b0000000010, S_ROT   = 10'b0000000100,
        S_SRD   = 10'b0000001000, S_SCMP  = 10'b0000010000, S_PRD   = 10'b0000100000,
        S_PCMP  = 10'b0001000000, S_SHRD  = 10'b0010000000, S_SHWR  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // table memory, one write and one registered read port
    logic [63:0]   r_mem [TABLE_DEPTH];
    logic [63:0]   r_rdata;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [63:0]   w_wdata;
    logic          w_we;

    t_state r_state;
    logic [4:0] r_base;
    logic [3:0] r_pairs;
    logic [CW-1:0] r_count;
    logic [1:0] r_mode;
    logic [63:0] r_req, r_canon, r_val;
    logic [DIGIT_W_T-1:0] r_dig [MAX_DIGITS];
    logic [DC-1:0] r_i, r_s, r_j;
    logic [4:0] r_b;
    logic [DC-1:0] r_n;
    logic [DIGIT_W_T-1:0] r_sum;
    logic [DIGIT_W_T-1:0] r_rem;
    logic [5:0] r_bit;
    logic [CW-1:0] r_lo, r_hi, r_k;
    logic r_found, r_added, r_ovf, r_out_v;
    logic [87:0] r_out;

    // effective radix and length
    logic [4:0] w_b;
    logic [3:0] w_p;
    always_comb begin
        w_b = (r_base < 5'd2) ? 5'd2 : (r_base > 5'd16) ? 5'd16 : r_base;
        w_p = (r_pairs < 4'd1) ? 4'd1 :
              ({1'b0, r_pairs} > 5'(MAX_DIGITS / 2)) ? 4'(MAX_DIGITS / 2) : r_pairs;
    end

    // mid of search range, digit index for rotation
    logic [CW:0] w_mid_full;
    logic [CW-1:0] w_mid;
    logic [DC:0] w_idx_full;
    logic [DI-1:0] w_idx;
    always_comb begin
        w_mid_full = {1'b0, r_lo} + (({1'b0, r_hi} - {1'b0, r_lo} + 1'b1) >> 1);
        w_mid = w_mid_full[CW-1:0];
        w_idx_full = {1'b0, r_j} + {1'b0, r_s};
        if (w_idx_full >= {1'b0, r_n}) w_idx_full = w_idx_full - {1'b0, r_n};
        w_idx = w_idx_full[DI-1:0];
    end

    // split: restoring division by the radix, one quotient bit a cycle
    logic [DIGIT_W_T:0]   w_t;
    logic                 w_qbit;
    logic [DIGIT_W_T-1:0] w_rem;
    logic [DIGIT_W_T:0]   w_sum_full;
    logic [DIGIT_W_T-1:0] w_sum_mod;
    always_comb begin
        w_t = {r_rem, r_req[63]};
        w_qbit = (w_t >= r_b);
        w_rem = w_qbit ? DIGIT_W_T'(w_t - r_b) : w_t[DIGIT_W_T-1:0];
        // digit sum kept modulo the radix
        w_sum_full = {1'b0, r_sum} + {1'b0, w_rem};
        w_sum_mod = (w_sum_full >= r_b) ? DIGIT_W_T'(w_sum_full - r_b)
                                        : w_sum_full[DIGIT_W_T-1:0];
    end

    logic [63:0] w_mac;
    always_comb w_mac = r_val * {59'd0, r_b} + {60'd0, r_dig[w_idx]};

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;

    always_comb begin
        w_raddr = '0;
        case (r_state)
            S_SRD:  w_raddr = AW'(w_mid);
            S_PRD:  w_raddr = AW'(r_lo);
            S_SHRD: w_raddr = AW'(r_k - 1'b1);
            default: w_raddr = '0;
        endcase
        w_we = 1'b0; w_waddr = '0; w_wdata = r_rdata;
        if (!i_rst_n) begin
            // entry zero holds zero after reset
            w_we = 1'b1; w_wdata = '0;
        end else if (r_state == S_SHWR) begin
            w_we = 1'b1;
            if (r_k == r_lo + 1'b1) begin
                w_waddr = AW'(r_k); w_wdata = r_canon;
            end else begin
                w_waddr = AW'(r_k);
            end
        end else if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready
                     && s_axis_tdata[1:0] == nab_pkg::MODE_CLEAR) begin
            w_we = 1'b1; w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= 5'd2; r_pairs <= 4'd2;
            r_count <= CW'(1);
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == nab_pkg::CFG_BASE) r_base <= i_cfg_data;
                else r_pairs <= i_cfg_data[3:0];
            end
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_mode <= s_axis_tdata[1:0];
                    r_req <= s_axis_tdata[65:2];
                    r_b <= w_b;
                    r_n <= DC'({w_p, 1'b0});
                    r_sum <= '0; r_canon <= '0;
                    r_rem <= '0; r_bit <= '0;
                    r_found <= 1'b0; r_added <= 1'b0; r_ovf <= 1'b0;
                    r_lo <= '0; r_hi <= r_count - 1'b1;
                    case (s_axis_tdata[1:0])
                        nab_pkg::MODE_INSERT: begin
                            r_i <= DC'(1); r_state <= S_SPLIT;
                        end
                        nab_pkg::MODE_LOOKUP: begin
                            r_i <= '0; r_state <= S_SPLIT;
                        end
                        nab_pkg::MODE_CLEAR: begin
                            r_count <= CW'(1); r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SPLIT: begin
                    if (r_i == r_n) begin
                        if (r_mode == nab_pkg::MODE_INSERT)
                            r_dig[0] <= (r_sum == '0) ? '0 : DIGIT_W_T'(r_b - {1'b0, r_sum});
                        r_s <= '0; r_j <= r_n; r_val <= '0;
                        r_state <= S_ROT;
                    end else begin
                        // quotient shifts in place, remainder becomes the digit
                        r_req <= {r_req[62:0], w_qbit};
                        r_bit <= r_bit + 1'b1;
                        if (r_bit == 6'd63) begin
                            r_dig[r_i[DI-1:0]] <= w_rem;
                            r_sum <= w_sum_mod;
                            r_rem <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_rem <= w_rem;
                        end
                    end
                end
                S_ROT: begin
                    if (r_j == '0) begin
                        if (r_s == '0 || r_val < r_canon) r_canon <= r_val;
                        r_val <= '0; r_j <= r_n;
                        if (r_s + 1'b1 == r_n) r_state <= (r_lo < r_hi) ? S_SRD : S_PRD;
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_rdata <= r_canon) begin
                        r_lo <= w_mid;
                        r_state <= (w_mid < r_hi) ? S_SRD : S_PRD;
                    end else begin
                        r_hi <= w_mid - 1'b1;
                        r_state <= (r_lo < w_mid - 1'b1) ? S_SRD : S_PRD;
                    end
                end
                S_PRD: r_state <= S_PCMP;
                S_PCMP: begin
                    if (r_rdata == r_canon) begin
                        r_found <= 1'b1; r_state <= S_OUT;
                    end else if (r_mode == nab_pkg::MODE_INSERT) begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            r_ovf <= 1'b1; r_state <= S_OUT;
                        end else begin
                            r_k <= r_count; r_state <= S_SHRD;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    if (r_k == r_lo + 1'b1) begin
                        r_count <= r_count + 1'b1; r_lo <= r_lo + 1'b1;
                        r_added <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_k <= r_k - 1'b1; r_state <= S_SHRD;
                    end
                end
                S_OUT: begin
                    r_out <= {11'(r_count), r_ovf, r_added, r_found, 10'(r_lo), r_canon};
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_ROT && r_j != '0) r_val <= w_mac;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
    logic w_unused;
    assign w_unused = ^s_axis_tdata[71:66];
endmodule
`default_nettype wire

[rtl/core/nab_checker.sv]
// port-level checks for the necklace address book
`default_nettype none
module nab_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [87:0] m_axis_tdata
);
    // result word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
    // no new word taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("busy");
    // accepted word is not ready again next cycle
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("one");
    // added and found never together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[74] && m_axis_tdata[75])) else $error("flags");
endmodule
bind necklace_address_book nab_checker u_nab_checker (.*);
`default_nettype wire

[dv/tb_necklace_address_book.sv]
// self-checking testbench for the necklace address book
`timescale 1ns / 100ps
`default_nettype none
module tb_necklace_address_book;

    localparam int DEPTH       = 1024;
    localparam int WDOG_LIMIT  = 60000;
    localparam int HOLD_CYCLES = 2000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [63:0] canon;
        logic [9:0]  pos;
        logic        found;
        logic        added;
        logic        ovf;
        logic [10:0] entries;
    } book_res_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_EXACT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  mode;
        logic [63:0] req;
        logic [0:0]  reg_idx;
        logic [4:0]  reg_val;
        book_res_t   want;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // [1:0] mode, [65:2] sequence_req, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;        // [63:0] canonical, [73:64] position, [74] found,
                                      // [75] added, [76] overflow, [87:77] entries

    necklace_address_book dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the address book
    logic [63:0] book_keys [0:DEPTH-1];
    int          book_count;
    logic [4:0]  shadow_base;
    logic [3:0]  shadow_pairs;

    book_res_t   pending_q [$];
    int          mismatches = 0;
    int          tx_pct = 0;
    int          rx_pct = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          stall_cycles = 0;

    // minimal rotation of the digit string (with its check digit on insert)
    function automatic logic [63:0] necklace_min(input logic [1:0] mode,
                                                 input logic [63:0] req);
        logic [63:0] rad, rest, best, v;
        int          n, sum;
        int          dig [16];
        rad = (shadow_base < 2) ? 64'd2 : (shadow_base > 16) ? 64'd16 : 64'(shadow_base);
        n = (shadow_pairs < 1) ? 2 : (shadow_pairs > 8) ? 16 : 2 * int'(shadow_pairs);
        rest = req;
        sum = 0;
        if (mode == nab_pkg::MODE_INSERT) begin
            for (int i = 1; i < n; i++) begin
                dig[i] = int'(rest % rad);
                rest = rest / rad;
                sum += dig[i];
            end
            dig[0] = (int'(rad) - sum % int'(rad)) % int'(rad);
        end else begin
            for (int i = 0; i < n; i++) begin
                dig[i] = int'(rest % rad);
                rest = rest / rad;
            end
        end
        best = '0;
        for (int s = 0; s < n; s++) begin
            v = '0;
            for (int i = n; i > 0; i--) v = v * rad + 64'(dig[(i - 1 + s) % n]);
            if (s == 0 || v < best) best = v;
        end
        return best;
    endfunction

    // one book operation on the shadow state
    function automatic book_res_t book_step(input logic [1:0] mode, input logic [63:0] req);
        book_res_t r;
        int        lo, hi, mid;
        r = '0;
        if (mode == nab_pkg::MODE_INSERT || mode == nab_pkg::MODE_LOOKUP) begin
            r.canon = necklace_min(mode, req);
            lo = 0;
            hi = book_count - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (book_keys[mid] <= r.canon) lo = mid;
                else hi = mid - 1;
            end
            r.pos = 10'(lo);
            if (book_keys[lo] == r.canon) begin
                r.found = 1'b1;
            end else if (mode == nab_pkg::MODE_INSERT) begin
                if (book_count >= DEPTH) begin
                    r.ovf = 1'b1;
                end else begin
                    for (int i = book_count; i > lo + 1; i--) book_keys[i] = book_keys[i - 1];
                    book_keys[lo + 1] = r.canon;
                    book_count++;
                    r.pos = 10'(lo + 1);
                    r.added = 1'b1;
                end
            end
        end else if (mode == nab_pkg::MODE_CLEAR) begin
            book_keys[0] = '0;
            book_count = 1;
        end
        r.entries = 11'(book_count);
        return r;
    endfunction

    // offer one word and record its expected result once taken
    task automatic push_word(input logic [1:0] mode, input logic [63:0] req,
                             input bit exact = 0, input book_res_t want = '0);
        book_res_t r;
        if ($urandom_range(0, 99) < tx_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, req, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = book_step(mode, req);
        pending_q.push_back(exact ? want : r);
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == nab_pkg::CFG_BASE) shadow_base = val;
        else shadow_pairs = val[3:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        book_res_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[63:0], m_axis_tdata[73:64], m_axis_tdata[74],
                   m_axis_tdata[75], m_axis_tdata[76], m_axis_tdata[87:77]};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: canon %h pos %0d", got.canon, got.pos);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp canon %h pos %0d f%0b a%0b o%0b n%0d",
                                  " | got canon %h pos %0d f%0b a%0b o%0b n%0d"},
                                 want.canon, want.pos, want.found, want.added, want.ovf,
                                 want.entries, got.canon, got.pos, got.found, got.added,
                                 got.ovf, got.entries);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    localparam logic [63:0] ONES = '1;

    dir_row_t dir_rows [] = '{
        '{ROW_EXACT, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd0,
          '{64'd0, 10'd0, 1'b1, 1'b0, 1'b0, 11'd1}},
        '{ROW_EXACT, nab_pkg::MODE_INSERT, 64'd0, nab_pkg::CFG_BASE, 5'd0,
          '{64'd0, 10'd0, 1'b1, 1'b0, 1'b0, 11'd1}},
        '{ROW_EXACT, nab_pkg::MODE_INSERT, ONES, nab_pkg::CFG_BASE, 5'd0,
          '{64'd15, 10'd1, 1'b0, 1'b1, 1'b0, 11'd2}},
        '{ROW_EXACT, nab_pkg::MODE_LOOKUP, ONES, nab_pkg::CFG_BASE, 5'd0,
          '{64'd15, 10'd1, 1'b1, 1'b0, 1'b0, 11'd2}},
        '{ROW_ITEM, nab_pkg::MODE_INSERT, 64'd1, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_ITEM, nab_pkg::MODE_LOOKUP, 64'd5, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_EXACT, MODE_SPARE, ONES, nab_pkg::CFG_BASE, 5'd0,
          '{64'd0, 10'd0, 1'b0, 1'b0, 1'b0, 11'd3}},
        '{ROW_EXACT, nab_pkg::MODE_CLEAR, ONES, nab_pkg::CFG_BASE, 5'd0,
          '{64'd0, 10'd0, 1'b0, 1'b0, 1'b0, 11'd1}},
        '{ROW_EXACT, nab_pkg::MODE_LOOKUP, 64'd15, nab_pkg::CFG_BASE, 5'd0,
          '{64'd15, 10'd0, 1'b0, 1'b0, 1'b0, 11'd1}},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_PAIRS, 5'd0, '0},
        '{ROW_ITEM, nab_pkg::MODE_INSERT, ONES, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_ITEM, nab_pkg::MODE_LOOKUP, 64'd2, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd31, '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_PAIRS, 5'd15, '0},
        '{ROW_ITEM, nab_pkg::MODE_INSERT, ONES, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_ITEM, nab_pkg::MODE_LOOKUP, ONES, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_ITEM, nab_pkg::MODE_LOOKUP, 64'h0123_4567_89AB_CDEF, nab_pkg::CFG_BASE, 5'd0,
          '0},
        '{ROW_ITEM, nab_pkg::MODE_INSERT, 64'd0, nab_pkg::CFG_BASE, 5'd0, '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd1, '0},
        '{ROW_ITEM, nab_pkg::MODE_INSERT, 64'h8000_0000_0000_0001, nab_pkg::CFG_BASE, 5'd0,
          '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd17, '0},
        '{ROW_ITEM, nab_pkg::MODE_LOOKUP, 64'hFEDC_BA98_7654_3210, nab_pkg::CFG_BASE, 5'd0,
          '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_BASE, 5'd2, '0},
        '{ROW_CFG, nab_pkg::MODE_LOOKUP, 64'd0, nab_pkg::CFG_PAIRS, 5'd2, '0}
    };

    initial begin
        logic [63:0] req, c;
        logic [27:0] upper;
        int          r, extra;

        book_keys[0] = '0;
        book_count   = 1;
        shadow_base  = 5'd2;
        shadow_pairs = 4'd2;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                push_word(dir_rows[k].mode, dir_rows[k].req,
                          dir_rows[k].kind == ROW_EXACT, dir_rows[k].want);
            end
        end
        drain();

        // random traffic under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            tx_pct = (ph == 0) ? 38 : (ph == 1) ? 46 : 0;
            rx_pct = (ph == 0) ? 46 : (ph == 1) ? 38 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                drain();
                r = $urandom_range(0, 3);
                write_reg(nab_pkg::CFG_BASE,
                          (r == 0) ? 5'd16 : (r == 1) ? 5'd2 : 5'($urandom_range(0, 31)));
                write_reg(nab_pkg::CFG_PAIRS, (blk == 0) ? 5'd8 : (blk == 1) ? 5'd1
                                                          : 5'($urandom_range(0, 15)));
                if (ph == 2 && blk == 0) hold_req = 1;
                for (int k = 0; k < 45; k++) begin
                    r = $urandom_range(0, 99);
                    req = {$urandom, $urandom};
                    if (r < 4)
                        push_word(nab_pkg::MODE_CLEAR, req);
                    else if (r < 7)
                        push_word(MODE_SPARE, req);
                    else if (r < 20)
                        push_word(nab_pkg::MODE_LOOKUP,
                                  book_keys[$urandom_range(0, book_count - 1)]);
                    else if (r < 35)
                        push_word(nab_pkg::MODE_LOOKUP, req);
                    else
                        push_word(nab_pkg::MODE_INSERT, req);
                end
            end
        end
        drain();

        // fill the book in ascending order, then overflow it
        write_reg(nab_pkg::CFG_BASE, 5'd16);
        write_reg(nab_pkg::CFG_PAIRS, 5'd4);
        push_word(nab_pkg::MODE_CLEAR, 64'd0);
        extra = 0;
        upper = 28'd256;
        while (extra < 3) begin
            req = {$urandom, $urandom};
            req[27:0] = upper;
            c = necklace_min(nab_pkg::MODE_INSERT, req);
            if (c > book_keys[book_count - 1]) begin
                if (book_count >= DEPTH) extra++;
                push_word(nab_pkg::MODE_INSERT, req);
            end
            upper++;
        end
        push_word(nab_pkg::MODE_INSERT, 64'd0);
        push_word(nab_pkg::MODE_LOOKUP, book_keys[DEPTH - 1]);
        push_word(nab_pkg::MODE_LOOKUP, book_keys[500]);
        push_word(nab_pkg::MODE_LOOKUP, ONES);
        push_word(nab_pkg::MODE_CLEAR, 64'd0);
        push_word(nab_pkg::MODE_LOOKUP, ONES);
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
